[rtl/core/pcmc_pkg.sv]
package pcmc_pkg;

	localparam int CountLimit = 60;
	localparam int CntW       = $clog2(CountLimit);
	localparam int DigW       = 4;
	localparam int Radix      = 10;
	// tens = (v * 103) >> 10 is exact for v below 100
	localparam int TensMul    = 103;
	localparam int TensShift  = 10;
	localparam int ProdW      = 17;
	localparam int WideW      = 7;

	typedef logic [CntW-1:0] cnt_t;
	typedef logic [DigW-1:0] digit_t;

	typedef struct packed {
		logic heat_down;
		logic heat_up;
		logic event_down;
		logic event_up;
	} btn_t;

	typedef struct packed {
		cnt_t left;
		cnt_t right;
	} pair_t;

	typedef struct packed {
		digit_t tens;
		digit_t units;
	} dec_t;

	function automatic dec_t to_dec(cnt_t v);
		logic [ProdW-1:0] prod;
		logic [WideW-1:0] rem;
		dec_t             d;
		prod    = ProdW'(v) * ProdW'(TensMul);
		d.tens  = DigW'(prod >> TensShift);
		rem     = WideW'(v) - WideW'(d.tens) * WideW'(Radix);
		d.units = DigW'(rem);
		return d;
	endfunction

endpackage

[rtl/core/pcmc_ifs.sv]
interface pcmc_tick_if;
	logic valid;
	logic ready;
	logic meet_mode;
	logic event_up_level;
	logic event_down_level;
	logic heat_up_level;
	logic heat_down_level;

	modport source (output valid, meet_mode, event_up_level, event_down_level,
		heat_up_level, heat_down_level, input ready);
	modport sink (input valid, meet_mode, event_up_level, event_down_level,
		heat_up_level, heat_down_level, output ready);
endinterface

interface pcmc_disp_if;
	import pcmc_pkg::*;
	logic   valid;
	logic   ready;
	logic   showing_meet;
	digit_t digit_left_tens;
	digit_t digit_left_units;
	digit_t digit_right_tens;
	digit_t digit_right_units;

	modport source (output valid, showing_meet, digit_left_tens, digit_left_units,
		digit_right_tens, digit_right_units, input ready);
	modport sink (input valid, showing_meet, digit_left_tens, digit_left_units,
		digit_right_tens, digit_right_units, output ready);
endinterface

[rtl/core/pcmc_pace.sv]
module pcmc_pace (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	output pcmc_pkg::pair_t nxt
);
	import pcmc_pkg::*;

	cnt_t            sec_q;
	cnt_t            min_q;
	cnt_t            sec_d;
	cnt_t            min_d;
	logic [CntW:0]   sec_inc;
	logic [CntW:0]   min_inc;

	always_comb begin
		sec_inc = {1'b0, sec_q} + (CntW+1)'(1);
		min_inc = {1'b0, min_q} + (CntW+1)'(1);
		sec_d   = CntW'(sec_inc);
		min_d   = min_q;
		if (sec_inc >= (CntW+1)'(CountLimit)) begin
			sec_d = '0;
			min_d = (min_inc >= (CntW+1)'(CountLimit)) ? '0 : CntW'(min_inc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= '0;
			min_q <= '0;
		end else if (en) begin
			sec_q <= sec_d;
			min_q <= min_d;
		end
	end

	assign nxt.left  = min_d;
	assign nxt.right = sec_d;

endmodule

[rtl/core/pcmc_meet.sv]
module pcmc_meet (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  pcmc_pkg::btn_t  levels,
	output pcmc_pkg::pair_t nxt
);
	import pcmc_pkg::*;

	btn_t prev_q;
	cnt_t evt_q;
	cnt_t heat_q;
	btn_t rise;
	cnt_t evt_d;
	cnt_t heat_d;

	function automatic cnt_t step(cnt_t v, logic up, logic down);
		logic [CntW:0] w;
		w = {1'b0, v};
		if (up && !down)
			w = w + (CntW+1)'(1);
		if (down && !up)
			w = w - (CntW+1)'(1);
		// below one (incl. wrap from zero) or at the limit falls back to one
		if (w == '0 || w >= (CntW+1)'(CountLimit))
			w = (CntW+1)'(1);
		return CntW'(w);
	endfunction

	always_comb begin
		rise   = levels & ~prev_q;
		evt_d  = step(evt_q, rise.event_up, rise.event_down);
		heat_d = step(heat_q, rise.heat_up, rise.heat_down);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			evt_q  <= CntW'(1);
			heat_q <= CntW'(1);
		end else if (en) begin
			prev_q <= levels;
			evt_q  <= evt_d;
			heat_q <= heat_d;
		end
	end

	assign nxt.left  = evt_d;
	assign nxt.right = heat_d;

endmodule

[rtl/core/pace_clock_meet_counter.sv]
// Pace clock / meet counter. Takes one tick request per cycle while tick.ready is
// high and presents one display request per tick: the tick is captured in an input
// register, then the counters update and the four decimal digits are formed,
// landing in the result register when it is free. Sustained rate is one tick per
// clock while the display side keeps taking requests; tick.ready
// drops only when the result register is full and not being taken. Pace mode
// counts mm:ss, meet mode steps event/heat numbers on button rising edges.
module pace_clock_meet_counter (
	input logic       clk,
	input logic       arst_n,
	pcmc_tick_if.sink tick,
	pcmc_disp_if.source disp
);
	import pcmc_pkg::*;

	logic  valid_s1;
	logic  meet_s1;
	btn_t  btn_s1;
	logic  s1_adv;
	logic  s2_free;
	pair_t pace_nxt;
	pair_t meet_nxt;
	pair_t sel;
	dec_t  left_dec;
	dec_t  right_dec;

	logic   out_valid_q;
	logic   showing_q;
	digit_t lt_q;
	digit_t lu_q;
	digit_t rt_q;
	digit_t ru_q;

	assign s2_free    = !out_valid_q || disp.ready;
	assign s1_adv     = valid_s1 && s2_free;
	assign tick.ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			meet_s1           <= tick.meet_mode;
			btn_s1.event_up   <= tick.event_up_level;
			btn_s1.event_down <= tick.event_down_level;
			btn_s1.heat_up    <= tick.heat_up_level;
			btn_s1.heat_down  <= tick.heat_down_level;
		end
	end

	pcmc_pace u_pace (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (s1_adv && !meet_s1),
		.nxt    (pace_nxt)
	);

	pcmc_meet u_meet (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (s1_adv && meet_s1),
		.levels (btn_s1),
		.nxt    (meet_nxt)
	);

	always_comb begin
		sel       = meet_s1 ? meet_nxt : pace_nxt;
		left_dec  = to_dec(sel.left);
		right_dec = to_dec(sel.right);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			showing_q <= meet_s1;
			lt_q      <= left_dec.tens;
			lu_q      <= left_dec.units;
			rt_q      <= right_dec.tens;
			ru_q      <= right_dec.units;
		end
	end

	assign disp.valid             = out_valid_q;
	assign disp.showing_meet      = showing_q;
	assign disp.digit_left_tens   = lt_q;
	assign disp.digit_left_units  = lu_q;
	assign disp.digit_right_tens  = rt_q;
	assign disp.digit_right_units = ru_q;

`ifndef NO_ASSERTIONS
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_valid_q)
		else $error("processed tick did not reach result register");

	a_digits_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (lt_q < DigW'(Radix)) && (lu_q < DigW'(Radix)) &&
			(rt_q < DigW'(Radix)) && (ru_q < DigW'(Radix)))
		else $error("digit out of decimal range");

	a_meet_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && showing_q) |-> !(lt_q == '0 && lu_q == '0) &&
			!(rt_q == '0 && ru_q == '0))
		else $error("event or heat shown as zero");
`endif

endmodule

[tb/testbench.sv]
module testbench;
	import pcmc_pkg::*;

	localparam int HalfPeriod  = 6;
	localparam int ResetCycles = 8;
	localparam int RandomTicks = 1700;
	localparam int MaxWait     = 12;
	localparam int DrainCycles = 8;
	localparam int IdleLimit   = 500;

	localparam btn_t BtnNone     = 4'b0000;
	localparam btn_t BtnEvUp     = 4'b0001;
	localparam btn_t BtnEvDown   = 4'b0010;
	localparam btn_t BtnHeatUp   = 4'b0100;
	localparam btn_t BtnHeatDown = 4'b1000;
	localparam btn_t BtnAll      = 4'b1111;

	typedef enum int {
		PhaseCalm,
		PhaseLight,
		PhaseFull
	} pace_phase_e;

	typedef enum int {
		RunPace,
		RunPress,
		RunNoise
	} run_kind_e;

	typedef struct packed {
		logic meet;
		btn_t btn;
	} tick_t;

	typedef struct packed {
		logic   showing_meet;
		digit_t left_tens;
		digit_t left_units;
		digit_t right_tens;
		digit_t right_units;
	} shown_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	pcmc_tick_if tick_ch ();
	pcmc_disp_if disp_ch ();

	pace_clock_meet_counter dut (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (tick_ch),
		.disp  (disp_ch)
	);

	always #HalfPeriod clk = ~clk;

	// driven values, known from time zero
	logic  drv_valid  = 1'b0;
	tick_t drv_item   = '0;
	logic  sink_ready = 1'b0;

	assign tick_ch.valid            = drv_valid;
	assign tick_ch.meet_mode        = drv_item.meet;
	assign tick_ch.event_up_level   = drv_item.btn.event_up;
	assign tick_ch.event_down_level = drv_item.btn.event_down;
	assign tick_ch.heat_up_level    = drv_item.btn.heat_up;
	assign tick_ch.heat_down_level  = drv_item.btn.heat_down;
	assign disp_ch.ready            = sink_ready;

	tick_t  tick_queue[$];
	shown_t display_queue[$];

	// predicted block state
	cnt_t pace_sec   = '0;
	cnt_t pace_min   = '0;
	cnt_t meet_event = cnt_t'(1);
	cnt_t meet_heat  = cnt_t'(1);
	btn_t last_btn   = BtnNone;

	int errors      = 0;
	int ticks_taken = 0;
	int pace_seen   = 0;
	int meet_seen   = 0;
	int hour_wraps  = 0;
	int clamp_hits  = 0;
	int idle_cycles = 0;
	int total_ticks = 0;

	logic tick_fire = 1'b0;
	logic disp_fire = 1'b0;

	pace_phase_e phase      = PhaseFull;
	int          phase_left = 0;
	logic        holding    = 1'b0;
	int          gap_left   = 0;
	int          stall_left = 0;

	// idle phases: some stretches run flat out, others stall hard
	function automatic int draw_wait();
		if (phase_left == 0) begin
			phase      = pace_phase_e'($urandom_range(0, 2));
			phase_left = $urandom_range(20, 150);
		end
		phase_left--;
		case (phase)
			PhaseCalm:  return 0;
			PhaseLight: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
			default:    return $urandom_range(0, MaxWait);
		endcase
	endfunction

	function automatic cnt_t step_counter(cnt_t v, logic up, logic dn);
		int n;
		n = v;
		if (up && !dn)
			n++;
		if (dn && !up)
			n--;
		if (n < 1 || n >= CountLimit) begin
			n = 1;
			clamp_hits++;
		end
		return cnt_t'(n);
	endfunction

	function automatic shown_t predict_display(tick_t t);
		btn_t   rise;
		int     left;
		int     right;
		shown_t s;
		if (!t.meet) begin
			pace_sec = pace_sec + 1'b1;
			if (pace_sec >= CountLimit) begin
				pace_sec = '0;
				pace_min = pace_min + 1'b1;
				if (pace_min >= CountLimit) begin
					pace_min = '0;
					hour_wraps++;
				end
			end
			left  = pace_min;
			right = pace_sec;
		end else begin
			rise       = t.btn & ~last_btn;
			last_btn   = t.btn;
			meet_event = step_counter(meet_event, rise.event_up, rise.event_down);
			meet_heat  = step_counter(meet_heat, rise.heat_up, rise.heat_down);
			left       = meet_event;
			right      = meet_heat;
		end
		s.showing_meet = t.meet;
		s.left_tens    = digit_t'(left / Radix);
		s.left_units   = digit_t'(left % Radix);
		s.right_tens   = digit_t'(right / Radix);
		s.right_units  = digit_t'(right % Radix);
		return s;
	endfunction

	task automatic report_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_display(shown_t got);
		shown_t want;
		if (display_queue.size() == 0) begin
			$display("%0t: unexpected display request %h", $time, got);
			errors++;
		end else begin
			want = display_queue.pop_front();
			report_field("showing_meet", want.showing_meet, got.showing_meet);
			report_field("digit_left_tens", want.left_tens, got.left_tens);
			report_field("digit_left_units", want.left_units, got.left_units);
			report_field("digit_right_tens", want.right_tens, got.right_tens);
			report_field("digit_right_units", want.right_units, got.right_units);
			if (want.showing_meet)
				meet_seen++;
			else
				pace_seen++;
		end
	endtask

	// sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			tick_fire = tick_ch.valid && tick_ch.ready;
			disp_fire = disp_ch.valid && disp_ch.ready;
			if (disp_fire)
				check_display('{disp_ch.showing_meet, disp_ch.digit_left_tens,
					disp_ch.digit_left_units, disp_ch.digit_right_tens,
					disp_ch.digit_right_units});
			if (tick_fire) begin
				display_queue.push_back(predict_display('{tick_ch.meet_mode,
					{tick_ch.heat_down_level, tick_ch.heat_up_level,
					tick_ch.event_down_level, tick_ch.event_up_level}}));
				ticks_taken++;
			end
			idle_cycles = (tick_fire || disp_fire) ? 0 : idle_cycles + 1;
		end
	end

	// tick driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (holding && tick_fire) begin
				holding  = 1'b0;
				gap_left = draw_wait();
			end
			if (!holding) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (tick_queue.size() > 0) begin
					drv_item <= tick_queue.pop_front();
					holding = 1'b1;
				end
			end
			drv_valid <= holding;
		end
	end

	// display sink: may stall after each request it takes
	always @(negedge clk) begin
		if (arst_n) begin
			if (disp_fire)
				stall_left = draw_wait();
			if (stall_left > 0) begin
				stall_left--;
				sink_ready <= 1'b0;
			end else begin
				sink_ready <= 1'b1;
			end
		end
	end

	task automatic add_tick(logic meet, btn_t btn);
		tick_queue.push_back('{meet, btn});
	endtask

	initial begin
		btn_t      masks[9];
		btn_t      mask;
		btn_t      base;
		run_kind_e kind;
		int        queued;
		int        len;
		int        pick;

		masks = '{BtnEvUp, BtnEvDown, BtnHeatUp, BtnHeatDown, BtnEvUp | BtnHeatUp,
			BtnEvDown | BtnHeatDown, BtnEvUp | BtnEvDown, BtnHeatUp | BtnHeatDown,
			BtnEvUp | BtnHeatDown};

		// pace ignores buttons and leaves the stored levels alone
		add_tick(1'b0, BtnNone);
		add_tick(1'b0, BtnAll);
		add_tick(1'b1, BtnNone);
		add_tick(1'b1, BtnEvUp);
		add_tick(1'b1, BtnEvUp);              // held, no edge
		add_tick(1'b1, BtnNone);
		add_tick(1'b1, BtnEvDown);
		add_tick(1'b1, BtnNone);
		add_tick(1'b1, BtnEvDown);            // below one, forced back
		add_tick(1'b1, BtnNone);
		add_tick(1'b1, BtnEvUp | BtnEvDown);  // both edges cancel
		add_tick(1'b1, BtnNone);
		add_tick(1'b1, BtnHeatUp);
		add_tick(1'b1, BtnNone);
		add_tick(1'b1, BtnHeatDown);
		add_tick(1'b1, BtnNone);
		add_tick(1'b1, BtnHeatDown);
		add_tick(1'b1, BtnNone);
		add_tick(1'b1, BtnHeatUp | BtnHeatDown);
		add_tick(1'b1, BtnNone);
		add_tick(1'b1, BtnAll);
		add_tick(1'b0, BtnAll);
		add_tick(1'b1, BtnAll);               // still held across pace
		add_tick(1'b1, BtnNone);
		add_tick(1'b0, BtnNone);

		queued = 0;
		while (queued < RandomTicks) begin
			pick = $urandom_range(0, 9);
			kind = (pick < 3) ? RunPace : (pick < 8) ? RunPress : RunNoise;
			case (kind)
				RunPace: begin
					len = $urandom_range(1, 80);
					repeat (len)
						add_tick(1'b0, btn_t'($urandom_range(0, 15)));
					queued += len;
				end
				RunPress: begin
					mask = masks[$urandom_range(0, 8)];
					// long single-up runs climb to the top and wrap
					if (mask == BtnEvUp || mask == BtnHeatUp)
						len = $urandom_range(1, 70);
					else
						len = $urandom_range(1, 20);
					base = btn_t'($urandom_range(0, 15)) & ~mask;
					repeat (len) begin
						add_tick(1'b1, base | mask);
						add_tick(1'b1, base);
					end
					queued += 2 * len;
				end
				default: begin
					len = $urandom_range(1, 20);
					repeat (len)
						add_tick(1'($urandom_range(0, 1)), btn_t'($urandom_range(0, 15)));
					queued += len;
				end
			endcase
		end

		repeat (20)
			add_tick(1'($urandom_range(0, 1)), btn_t'($urandom_range(0, 15)));

		total_ticks = tick_queue.size();

		repeat (ResetCycles) @(negedge clk);
		arst_n <= 1'b1;

		while ((ticks_taken < total_ticks || display_queue.size() > 0)
				&& idle_cycles < IdleLimit)
			@(negedge clk);
		if (idle_cycles >= IdleLimit) begin
			$display("%0t: watchdog expired, %0d of %0d ticks taken",
				$time, ticks_taken, total_ticks);
			errors++;
		end else begin
			repeat (DrainCycles) @(negedge clk);
		end
		if (display_queue.size() > 0) begin
			$display("%0t: %0d display requests never arrived", $time, display_queue.size());
			errors++;
		end

		$display("%0d ticks sent, %0d pace and %0d meet displays checked",
			ticks_taken, pace_seen, meet_seen);
		$display("%0d hour rollovers, %0d event/heat clamps to one", hour_wraps, clamp_hits);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
